### rtl/core/acss_pkg.sv
// ----------------------------------------------------------------------------
// acss_pkg
// Shared types and constants of the ascending chunk size schedule.
// ----------------------------------------------------------------------------
package acss_pkg;

   localparam int IDX_W      = 32;
   localparam int BYTES_W    = 31;
   localparam int SPLIT_W    = 16;
   localparam int STEP_SHIFT = 23;
   localparam int M_W        = 23;
   localparam int QUO_W      = 31;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int MID_DEPTH_DEF = 4;
   localparam int OUT_DEPTH_DEF = 2;

   // (max - step) / step
   localparam int CHUNK_MULT = (1 << (BYTES_W - 1 - STEP_SHIFT)) - 1;

   localparam logic [BYTES_W-1:0] MAX_CHUNK_BYTES = BYTES_W'(1 << (BYTES_W - 1));
   localparam logic [BYTES_W-1:0] DEFAULT_BYTES_RESET = BYTES_W'(32'h0100_0000);
   localparam logic [SPLIT_W-1:0] SPLIT_START_RESET = SPLIT_W'(0);
   localparam logic [SPLIT_W-1:0] SPLIT_END_RESET = SPLIT_W'(1);

   localparam logic [CSR_ADDR_W-1:0] CSR_DEFAULT_BYTES = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_SPLIT_START   = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_SPLIT_END     = CSR_ADDR_W'(2);

   typedef enum logic [1:0] {
      CLS_ERROR,
      CLS_LOW,
      CLS_HIGH,
      CLS_RANGE
   } cls_type;

   typedef struct packed {
      logic [BYTES_W-1:0] default_bytes;
      logic [SPLIT_W-1:0] split_start;
      logic [SPLIT_W-1:0] split_end;
   } cfg_type;

   typedef struct packed {
      cls_type            cls;
      logic [M_W-1:0]     mult;
      logic [SPLIT_W-1:0] span;
   } item_type;

   typedef struct packed {
      logic [BYTES_W-1:0] chunk_bytes;
      logic               config_error;
   } rsp_type;

endpackage

### rtl/core/ascending_chunk_size_schedule_top.sv
// ----------------------------------------------------------------------------
// ascending_chunk_size_schedule_top
// Chunk size schedule: default size below the split range, maximum above it,
// a scaled and rounded size inside it; an error word on an empty range.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   req     | in        | req_push / req_full  | req_chunk_index
//   rsp     | out       | rsp_pop / rsp_empty  | rsp_chunk_bytes, rsp_config_error
//   csr     | in        | csr_valid / csr_ready| csr_index, csr_data
//
// One word per cycle while the result queue has room. After the input stage
// takes a word it passes the mid queue, divider load, 31 divider stages (one
// quotient bit per stage), result register and result queue.
// Reset is synchronous: queues and pipe valids clear, registers take defaults.
// While the result queue is full the divider pipe holds as a whole; the input
// stage keeps taking words until the mid queue fills.
// ----------------------------------------------------------------------------
module ascending_chunk_size_schedule_top
   import acss_pkg::*;
#(
   parameter int MID_DEPTH = MID_DEPTH_DEF,
   parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [IDX_W-1:0]      req_chunk_index,
   output logic                  req_full,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic [BYTES_W-1:0]    rsp_chunk_bytes,
   output logic                  rsp_config_error,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type                 cfg_ff, cfg_in;
   logic                    mid_push, mid_full, mid_empty, mid_pop;
   item_type                front_item, mid_item;
   logic [$bits(item_type)-1:0] mid_data;
   logic                    div_enable, div_out_valid, out_full, out_push;
   rsp_type                 div_rsp, rsp_word;
   logic [$bits(rsp_type)-1:0] rsp_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEFAULT_BYTES: cfg_in.default_bytes = csr_data[BYTES_W-1:0];
            CSR_SPLIT_START:   cfg_in.split_start   = csr_data[SPLIT_W-1:0];
            CSR_SPLIT_END:     cfg_in.split_end     = csr_data[SPLIT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_bytes <= DEFAULT_BYTES_RESET;
         cfg_ff.split_start   <= SPLIT_START_RESET;
         cfg_ff.split_end     <= SPLIT_END_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   acss_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_chunk_index (req_chunk_index),
      .req_full        (req_full),
      .cfg             (cfg_ff),
      .mid_push        (mid_push),
      .mid_item        (front_item),
      .mid_full        (mid_full)
   );

   acss_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (front_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .empty     (mid_empty)
   );

   assign mid_item   = item_type'(mid_data);
   assign div_enable = !out_full;
   assign mid_pop    = !mid_empty && div_enable;
   assign out_push   = div_out_valid && !out_full;

   acss_div u_div (
      .clock         (clock),
      .reset         (reset),
      .enable        (div_enable),
      .in_valid      (!mid_empty),
      .in_item       (mid_item),
      .default_bytes (cfg_ff.default_bytes),
      .out_valid     (div_out_valid),
      .out_rsp       (div_rsp)
   );

   acss_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (div_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   assign rsp_word         = rsp_type'(rsp_data);
   assign rsp_chunk_bytes  = rsp_word.chunk_bytes;
   assign rsp_config_error = rsp_word.config_error;

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (!rsp_config_error || rsp_chunk_bytes == '0))
      else $error("error word with nonzero size");

endmodule

### rtl/core/acss_fifo.sv
// ----------------------------------------------------------------------------
// acss_fifo
// Small register queue with count, used between front and back and on results.
// ----------------------------------------------------------------------------
module acss_fifo
   import acss_pkg::*;
#(
   parameter int WIDTH = $bits(rsp_type),
   parameter int DEPTH = OUT_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_push_fills : assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> !empty)
      else $error("queue empty after accepted word");

endmodule

### rtl/core/acss_front.sv
// ----------------------------------------------------------------------------
// acss_front
// Input stage: takes a chunk index, classifies it against the split range and
// forms the dividend multiplier and the span.
// ----------------------------------------------------------------------------
module acss_front
   import acss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [IDX_W-1:0] req_chunk_index,
   output logic             req_full,
   input  cfg_type          cfg,
   output logic             mid_push,
   output item_type         mid_item,
   input  logic             mid_full
);

   logic                 valid_ff, valid_in;
   item_type             item_ff, item_in;
   logic                 accept, drain;
   logic [SPLIT_W:0]     count_n;
   logic [M_W:0]         mult_wide;

   assign drain    = valid_ff && !mid_full;
   assign req_full = valid_ff && mid_full;
   assign accept   = req_push && !req_full;
   assign valid_in = accept || (valid_ff && !drain);
   assign mid_push = valid_ff;
   assign mid_item = item_ff;

   always_comb begin
      count_n   = {1'b0, req_chunk_index[SPLIT_W-1:0]} - {1'b0, cfg.split_start}
                  + (SPLIT_W + 1)'(1);
      mult_wide = (M_W + 1)'(count_n) * (M_W + 1)'(CHUNK_MULT);
      item_in.mult = mult_wide[M_W-1:0];
      item_in.span = cfg.split_end - cfg.split_start;
      if (cfg.split_end <= cfg.split_start) begin
         item_in.cls = CLS_ERROR;
      end else if (req_chunk_index < IDX_W'(cfg.split_start)) begin
         item_in.cls = CLS_LOW;
      end else if (req_chunk_index > IDX_W'(cfg.split_end)) begin
         item_in.cls = CLS_HIGH;
      end else begin
         item_in.cls = CLS_RANGE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

### rtl/core/acss_div.sv
// ----------------------------------------------------------------------------
// acss_div
// Back end: pipelined restoring divider, one quotient bit per stage, then
// floor and round-up to the step size. The whole pipe holds when enable is low.
// ----------------------------------------------------------------------------
module acss_div
   import acss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  item_type           in_item,
   input  logic [BYTES_W-1:0] default_bytes,
   output logic               out_valid,
   output rsp_type            out_rsp
);

   localparam int DVD_W = M_W + STEP_SHIFT;
   localparam int HI_W  = QUO_W - STEP_SHIFT;

   logic               valid_ff [QUO_W+1];
   cls_type            cls_ff   [QUO_W+1];
   logic [SPLIT_W-1:0] span_ff  [QUO_W+1];
   logic [SPLIT_W-1:0] rem_ff   [QUO_W+1];
   logic [QUO_W-1:0]   num_ff   [QUO_W+1];
   logic [QUO_W-1:0]   quo_ff   [QUO_W+1];

   logic [DVD_W-1:0]   dividend;
   logic               out_valid_ff;
   rsp_type            out_rsp_ff, out_rsp_in;
   logic [QUO_W-1:0]   quo;
   logic [HI_W-1:0]    quo_hi_inc;
   logic [QUO_W-1:0]   quo_rounded;

   assign dividend = {in_item.mult, {STEP_SHIFT{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cls_ff[0]  <= in_item.cls;
         span_ff[0] <= in_item.span;
         rem_ff[0]  <= SPLIT_W'(dividend[DVD_W-1:QUO_W]);
         num_ff[0]  <= dividend[QUO_W-1:0];
         quo_ff[0]  <= '0;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [SPLIT_W:0] trial;
      logic [SPLIT_W:0] diff;
      logic             take;

      always_comb begin
         trial = {rem_ff[k], num_ff[k][QUO_W-1]};
         diff  = trial - {1'b0, span_ff[k]};
         take  = (trial >= {1'b0, span_ff[k]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            cls_ff[k+1]  <= cls_ff[k];
            span_ff[k+1] <= span_ff[k];
            rem_ff[k+1]  <= take ? diff[SPLIT_W-1:0] : trial[SPLIT_W-1:0];
            num_ff[k+1]  <= {num_ff[k][QUO_W-2:0], 1'b0};
            quo_ff[k+1]  <= {quo_ff[k][QUO_W-2:0], take};
         end
      end
   end

   always_comb begin
      quo         = quo_ff[QUO_W];
      quo_hi_inc  = quo[QUO_W-1:STEP_SHIFT] + HI_W'(1);
      quo_rounded = (quo[STEP_SHIFT-1:0] != '0) ? {quo_hi_inc, {STEP_SHIFT{1'b0}}} : quo;
      out_rsp_in.config_error = 1'b0;
      unique case (cls_ff[QUO_W])
         CLS_ERROR: begin
            out_rsp_in.chunk_bytes  = '0;
            out_rsp_in.config_error = 1'b1;
         end
         CLS_LOW: begin
            out_rsp_in.chunk_bytes = default_bytes;
         end
         CLS_HIGH: begin
            out_rsp_in.chunk_bytes = MAX_CHUNK_BYTES;
         end
         CLS_RANGE: begin
            out_rsp_in.chunk_bytes = (quo <= default_bytes) ? default_bytes :
                                     BYTES_W'(quo_rounded);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= valid_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = out_rsp_ff;

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (!enable && out_valid_ff) |=> (out_valid_ff && $stable(out_rsp_ff)))
      else $error("divider output changed while stalled");

   a_rem_below_span : assert property (@(posedge clock) disable iff (reset)
      (valid_ff[QUO_W] && cls_ff[QUO_W] == CLS_RANGE) |-> (rem_ff[QUO_W] < span_ff[QUO_W]))
      else $error("divider remainder not below span");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the ascending chunk size schedule. Chunk indices are pushed
// under several schedule settings (reset values, broken splits, range edges,
// extreme defaults, then random settings), each result word is predicted
// when its index is accepted and compared in order with what the block pops.
// Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top
   import acss_pkg::*;
();

   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = CSR_ADDR_W'(3);
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [31:0] STEP_BYTES = 32'd1 << STEP_SHIFT;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic [IDX_W-1:0]      req_chunk_index;
   logic                  req_full;
   logic                  rsp_pop;
   logic                  rsp_empty;
   logic [BYTES_W-1:0]    rsp_chunk_bytes;
   logic                  rsp_config_error;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // schedule as the block should hold it
   logic [BYTES_W-1:0] sched_default;
   logic [SPLIT_W-1:0] sched_start;
   logic [SPLIT_W-1:0] sched_end;

   rsp_type pending_sizes[$];
   int      words_sent;
   int      words_checked;
   int      error_count;
   int      cycle_count;
   int      idle_pct;

   ascending_chunk_size_schedule_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_chunk_index  (req_chunk_index),
      .req_full         (req_full),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_chunk_bytes  (rsp_chunk_bytes),
      .rsp_config_error (rsp_config_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_type chunk_size_of(input logic [IDX_W-1:0] idx);
      rsp_type         r;
      longint unsigned ramp;
      longint unsigned q;
      longint unsigned rem;
      r = '0;
      ramp = 64'(MAX_CHUNK_BYTES) - 64'(STEP_BYTES);
      if (sched_end <= sched_start) begin
         r.config_error = 1'b1;
      end else if (idx < IDX_W'(sched_start)) begin
         r.chunk_bytes = sched_default;
      end else if (idx > IDX_W'(sched_end)) begin
         r.chunk_bytes = MAX_CHUNK_BYTES;
      end else begin
         q = ramp * (64'(idx) - 64'(sched_start) + 64'd1) /
             (64'(sched_end) - 64'(sched_start));
         if (q <= 64'(sched_default)) begin
            r.chunk_bytes = sched_default;
         end else begin
            rem = q % 64'(STEP_BYTES);
            if (rem != 0) q = q + 64'(STEP_BYTES) - rem;
            r.chunk_bytes = q[BYTES_W-1:0];
         end
      end
      return r;
   endfunction

   // predict on accept, compare on pop
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            got.chunk_bytes = rsp_chunk_bytes;
            got.config_error = rsp_config_error;
            if (pending_sizes.size() == 0) begin
               $display("%0t unexpected word: expected none actual %0d/%0b", $time,
                        got.chunk_bytes, got.config_error);
               error_count++;
            end else begin
               want = pending_sizes.pop_front();
               if (got.chunk_bytes !== want.chunk_bytes) begin
                  $display("%0t chunk_bytes: expected %0d actual %0d", $time,
                           want.chunk_bytes, got.chunk_bytes);
                  error_count++;
               end
               if (got.config_error !== want.config_error) begin
                  $display("%0t config_error: expected %0b actual %0b", $time,
                           want.config_error, got.config_error);
                  error_count++;
               end
            end
            words_checked++;
         end
         if (req_push && !req_full) pending_sizes.push_back(chunk_size_of(req_chunk_index));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // result side stalls
   initial begin
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
      end
   end

   task automatic push_index(input logic [IDX_W-1:0] idx);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chunk_index <= idx;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (words_checked < words_sent);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_DEFAULT_BYTES: sched_default = data[BYTES_W-1:0];
         CSR_SPLIT_START: sched_start = data[SPLIT_W-1:0];
         CSR_SPLIT_END: sched_end = data[SPLIT_W-1:0];
         default: ;
      endcase
   endtask

   // only while idle; the unused index gets junk and must change nothing
   task automatic set_schedule(input logic [CSR_DATA_W-1:0] dflt,
                               input logic [CSR_DATA_W-1:0] start,
                               input logic [CSR_DATA_W-1:0] stop);
      wait_drained();
      csr_write(CSR_DEFAULT_BYTES, dflt);
      csr_write(CSR_SPLIT_START, start);
      csr_write(CSR_SPLIT_END, stop);
      csr_write(CSR_UNUSED, $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_schedule();
      push_index(32'd0);
      push_index(32'd1);
      push_index(32'd2);
      push_index(32'hFFFF_FFFF);
   endtask

   task automatic test_bad_split();
      set_schedule(32'h0100_0000, 32'd5, 32'd5);
      push_index(32'd0);
      push_index(32'd5);
      set_schedule(32'h0100_0000, 32'hFFFF_FFFF, 32'hFFFF_0000);
      push_index(32'hFFFF_FFFF);
   endtask

   task automatic test_split_edges();
      // span 127 makes every quotient an exact step multiple
      set_schedule(32'h8100_0000, 32'hABCD_0064, 32'h1234_00E3);
      push_index(32'd99);
      push_index(32'd100);
      push_index(32'd101);
      push_index(32'd227);
      push_index(32'd228);
      // quotient equal to the default
      set_schedule(3 * STEP_BYTES, 32'd100, 32'd227);
      push_index(32'd102);
      push_index(32'd103);
   endtask

   task automatic test_default_extremes();
      set_schedule(32'd0, 32'd1000, 32'd65535);
      push_index(32'd0);
      push_index(32'd999);
      push_index(32'd1000);
      set_schedule(32'h7FFF_FFFF, 32'd1000, 32'd65535);
      push_index(32'd999);
      push_index(32'd1000);
      push_index(32'd65535);
      push_index(32'd65536);
      set_schedule(32'd1, 32'd0, 32'd65535);
      push_index(32'd0);
      push_index(32'd65535);
   endtask

   task automatic random_schedule();
      logic [BYTES_W-1:0] dflt;
      int                 start;
      int                 stop;
      int                 span;
      case ($urandom_range(0, 5))
         0: dflt = '0;
         1: dflt = '1;
         2: dflt = BYTES_W'(1);
         3: dflt = BYTES_W'($urandom_range(1, 32'd1 << 30));
         4: dflt = BYTES_W'($urandom);
         default: dflt = BYTES_W'(STEP_BYTES * $urandom_range(1, 128));
      endcase
      start = $urandom_range(0, 65535);
      case ($urandom_range(0, 6))
         0: stop = start;
         1: stop = $urandom_range(0, start);
         2: begin
            span = $urandom_range(1, 4);
            if (start + span > 65535) start = 65535 - span;
            stop = start + span;
         end
         3: begin
            start = 0;
            stop = 65535;
         end
         4: begin
            start = $urandom_range(0, 200);
            stop = start + $urandom_range(1, 300);
         end
         default: begin
            if (start == 65535) start = 65534;
            stop = $urandom_range(start + 1, 65535);
         end
      endcase
      set_schedule({1'($urandom_range(0, 1)), dflt},
                   {SPLIT_W'($urandom_range(0, 65535)), SPLIT_W'(start)},
                   {SPLIT_W'($urandom_range(0, 65535)), SPLIT_W'(stop)});
   endtask

   function automatic logic [IDX_W-1:0] random_index();
      int lo;
      int hi;
      lo = (sched_start > 2) ? sched_start - 2 : 0;
      hi = sched_end + 2;
      if (hi < lo) hi = lo + 4;
      case ($urandom_range(0, 9))
         6: return $urandom;
         7: return IDX_W'($urandom_range(0, 3));
         8: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         9: return IDX_W'($urandom_range(0, 65537));
         default: return IDX_W'($urandom_range(lo, hi));
      endcase
   endfunction

   task automatic test_random_schedules();
      int phases;
      phases = 12;
      for (int p = 0; p < phases; p++) begin
         random_schedule();
         if (p == phases - 1) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 15;
               default: idle_pct = 40;
            endcase
         end
         repeat (84) push_index(random_index());
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_push <= 1'b0;
      req_chunk_index <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      sched_default = DEFAULT_BYTES_RESET;
      sched_start = SPLIT_START_RESET;
      sched_end = SPLIT_END_RESET;
      words_sent = 0;
      words_checked = 0;
      error_count = 0;
      cycle_count = 0;
      idle_pct = 20;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_schedule();
      test_bad_split();
      test_split_edges();
      test_default_extremes();
      test_random_schedules();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_sizes.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
